### sv/jsfr_pkg.sv
package jsfr_pkg;

    // Defaults for the top-level parameters
    localparam int StoreBytesDefault = 128;
    localparam int JointCountDefault = 7;

    // Frame format
    localparam logic [7:0] SyncFirst   = 8'h55;
    localparam logic [7:0] SyncSecond  = 8'hAA;
    localparam int         LenOffset   = 4;
    localparam int         LenExtra    = 6;
    localparam int         JointBase   = 5;
    localparam int         JointStride = 8;
    localparam logic [8:0] LenReset    = 9'd14;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_FILL
    } t_state;

endpackage

### sv/joint_status_frame_receiver_core.sv
// Joint status frame receiver.
//
// Input channel (i_valid / o_stall, payload i_rx_byte): one byte from the serial
// link per beat. The core hunts for the sync pair 0x55, 0xAA, stores the frame
// from offset 2 on in a byte-wide frame memory and takes the byte at offset 4
// plus 6 as the frame length. A frame that reaches the end of the memory before
// its length is dropped without results.
// Output channel (o_valid / i_stall): when a frame completes, the core emits
// JOINT_COUNT beats, one per joint, with the big-endian current and position
// words read back from the memory, the running frame count and a last flag.
// Throughput: one byte per cycle while hunting or receiving. After the last
// byte of a frame the input is stalled while the results are read out: the
// bytes of each joint are read in turn through the single read port, then
// the output register is loaded. o_stall stays high until the last joint is
// loaded, and longer while the receiver stalls that load.
// The output register parts the two sides: a beat held by i_stall does not
// keep the core from hunting for the next frame.
// Reset clears the control state, the frame counter and the per-byte valid
// bits of the frame memory (an unwritten byte reads as zero); no clearing pass.
module joint_status_frame_receiver_core
    import jsfr_pkg::*;
#(
    parameter int STORE_BYTES = StoreBytesDefault,
    parameter int JOINT_COUNT = JointCountDefault
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input byte channel
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_rx_byte,
    // joint result channel
    output logic               o_valid,
    input  logic               i_stall,
    output logic [2:0]         o_joint_number,
    output logic signed [31:0] o_joint_current,
    output logic signed [31:0] o_joint_position,
    output logic [31:0]        o_frame_count,
    output logic               o_last_joint
);

    // Memory index, write index (can hold STORE_BYTES itself), joint counter
    localparam int IdxW   = $clog2(STORE_BYTES);
    localparam int WiW    = $clog2(STORE_BYTES + 1);
    localparam int JW     = $clog2(JOINT_COUNT + 1);
    localparam int MaxOff = JointBase + JointStride * JOINT_COUNT - 1;
    localparam int OffW   = $clog2(MaxOff + 1);
    localparam int CW     = (OffW > WiW) ? OffW : WiW;

    // Frame memory and its per-byte valid bits
    logic [7:0]             r_mem [STORE_BYTES];
    logic [STORE_BYTES-1:0] r_valid;

    // Control state
    t_state        r_state, n_state;
    logic          r_in_frame, n_in_frame;
    logic [7:0]    r_prev, n_prev;
    logic [WiW-1:0] r_widx, n_widx;
    logic [8:0]    r_explen, n_explen;
    logic [31:0]   r_frames, n_frames;
    logic [JW-1:0] r_joint, n_joint;
    logic [2:0]    r_bcnt, n_bcnt;
    logic [2:0]    r_num, n_num;
    logic          r_rd_pend;

    // Read path
    logic [7:0]    r_rd_data;
    logic          r_rd_ok;
    logic [55:0]   r_asm;
    logic [CW-1:0] rd_off;
    logic          rd_inrange;
    logic [7:0]    rd_byte;

    // Output register
    logic          r_out_valid, n_out_valid;
    logic [2:0]    r_out_num;
    logic [31:0]   r_out_cur;
    logic [31:0]   r_out_pos;
    logic [31:0]   r_out_frames;
    logic          r_out_last;
    logic          out_load;

    // Byte handling
    logic          in_acc;
    logic          wr_en;
    logic [WiW-1:0] widx_inc;
    logic [8:0]    len_now;
    logic          last_joint;

    assign in_acc     = i_valid && !o_stall;
    assign wr_en      = in_acc && (r_widx < WiW'(STORE_BYTES));
    assign widx_inc   = r_widx + WiW'(1);
    assign last_joint = (r_joint == JW'(JOINT_COUNT - 1));

    // Byte offset of the current read: base of the joint plus byte within it
    assign rd_off     = CW'(JointBase) + (CW'(r_joint) << 3) + CW'(r_bcnt);
    assign rd_inrange = (rd_off < CW'(STORE_BYTES));
    assign rd_byte    = r_rd_ok ? r_rd_data : 8'h00;

    // Length byte takes effect on the same beat it arrives
    assign len_now = (r_widx == WiW'(LenOffset)) ? (9'(i_rx_byte) + 9'(LenExtra))
                                                 : r_explen;

    always_comb begin
        n_state     = r_state;
        n_in_frame  = r_in_frame;
        n_prev      = r_prev;
        n_widx      = r_widx;
        n_explen    = r_explen;
        n_frames    = r_frames;
        n_joint     = r_joint;
        n_bcnt      = r_bcnt;
        n_num       = r_num;
        out_load    = 1'b0;
        n_out_valid = r_out_valid && i_stall;
        o_stall     = (r_state != ST_IDLE);

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (!r_in_frame && r_prev == SyncFirst && i_rx_byte == SyncSecond) begin
                        // sync found: restart the frame at offset 2
                        n_in_frame = 1'b1;
                        n_widx     = WiW'(2);
                        n_prev     = 8'h00;
                    end else if (r_in_frame) begin
                        n_explen = len_now;
                        n_widx   = widx_inc;
                        if (9'(widx_inc) == len_now) begin
                            // frame complete: count it and start the read-out
                            n_in_frame = 1'b0;
                            n_frames   = r_frames + 32'd1;
                            n_state    = ST_READ;
                            n_joint    = '0;
                            n_bcnt     = '0;
                            n_num      = '0;
                        end
                        if (widx_inc >= WiW'(STORE_BYTES)) begin
                            // drop the frame; park the index at the end
                            n_in_frame = 1'b0;
                        end
                    end else begin
                        n_prev = i_rx_byte;
                    end
                end
            end
            ST_READ: begin
                // issue one byte read a cycle
                if (r_bcnt == 3'd7) begin
                    n_state = ST_FILL;
                end else begin
                    n_bcnt = r_bcnt + 3'd1;
                end
            end
            ST_FILL: begin
                // last byte is in the read register; load when output frees up
                if (!r_out_valid || !i_stall) begin
                    out_load    = 1'b1;
                    n_out_valid = 1'b1;
                    n_bcnt      = '0;
                    if (last_joint) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_state = ST_READ;
                        n_joint = r_joint + JW'(1);
                        n_num   = r_num + 3'd1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_in_frame  <= 1'b0;
            r_prev      <= 8'h00;
            r_widx      <= '0;
            r_explen    <= LenReset;
            r_frames    <= 32'd0;
            r_joint     <= '0;
            r_bcnt      <= '0;
            r_num       <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
            r_valid     <= '0;
        end else begin
            r_state     <= n_state;
            r_in_frame  <= n_in_frame;
            r_prev      <= n_prev;
            r_widx      <= n_widx;
            r_explen    <= n_explen;
            r_frames    <= n_frames;
            r_joint     <= n_joint;
            r_bcnt      <= n_bcnt;
            r_num       <= n_num;
            r_rd_pend   <= (r_state == ST_READ);
            r_out_valid <= n_out_valid;
            if (wr_en) begin
                r_valid[r_widx[IdxW-1:0]] <= 1'b1;
            end
        end
    end

    // Frame memory: one write port for incoming bytes, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_widx[IdxW-1:0]] <= i_rx_byte;
        end
        r_rd_data <= r_mem[rd_off[IdxW-1:0]];
    end

    // Offsets past the memory and never-written bytes read as zero
    always_ff @(posedge i_clk) begin
        r_rd_ok <= rd_inrange && r_valid[rd_off[IdxW-1:0]];
    end

    // Assemble the first seven bytes of a joint, then load the output register
    always_ff @(posedge i_clk) begin
        if (r_state == ST_READ && r_rd_pend) begin
            r_asm <= {r_asm[47:0], rd_byte};
        end
        if (out_load) begin
            r_out_num    <= r_num;
            r_out_cur    <= r_asm[55:24];
            r_out_pos    <= {r_asm[23:0], rd_byte};
            r_out_frames <= r_frames;
            r_out_last   <= last_joint;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_joint_number   = r_out_num;
    assign o_joint_current  = $signed(r_out_cur);
    assign o_joint_position = $signed(r_out_pos);
    assign o_frame_count    = r_out_frames;
    assign o_last_joint     = r_out_last;

endmodule
